/* sv/m2au_pkg.sv */
// Package for the 2x2 matrix arithmetic unit: widths, mode and status codes,
// and the request and response transaction types.
// No dependencies; every other file of the unit refers to it by scoped names.
package m2au_pkg;

    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int DIV_STEPS     = DATA_W;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MODE_W        = 4;
    localparam int STATUS_W      = 2;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_NEG   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MV    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_VM    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_SCALE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DIV   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DET   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_TRACE = 4'd9;
    localparam logic [MODE_W-1:0] MODE_TRANS = 4'd10;
    localparam logic [MODE_W-1:0] MODE_INV   = 4'd11;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] a_xx;
        logic signed [DATA_W-1:0] a_xy;
        logic signed [DATA_W-1:0] a_yx;
        logic signed [DATA_W-1:0] a_yy;
        logic signed [DATA_W-1:0] b_xx;
        logic signed [DATA_W-1:0] b_xy;
        logic signed [DATA_W-1:0] b_yx;
        logic signed [DATA_W-1:0] b_yy;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_xx;
        logic signed [DATA_W-1:0] r_xy;
        logic signed [DATA_W-1:0] r_yx;
        logic signed [DATA_W-1:0] r_yy;
        logic [STATUS_W-1:0]      status;
    } rsp_t;

endpackage

/* sv/matrix2x2_arithmetic_unit.sv */
// Top level of the 2x2 matrix arithmetic unit in signed fixed point.
// Depends on m2au_pkg and m2au_div.
//
//  Channel | Signals                          | Payload
//  --------+----------------------------------+----------------------------
//  request | req_valid, req_ready, req_data   | m2au_pkg::req_t: mode, A, B
//  response| rsp_valid, rsp_ready, rsp_data   | m2au_pkg::rsp_t: R, status
//
// One transaction enters per cycle unless the response is stalled; the pipeline
// has 38 register stages. The depth is set by the divider, which resolves one
// quotient bit per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled response freezes the pipeline; the input stage still fills if empty.
module matrix2x2_arithmetic_unit #(
    parameter int FRAC_BITS = m2au_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  m2au_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output m2au_pkg::rsp_t  rsp_data
);

    localparam int W     = m2au_pkg::DATA_W;
    localparam int L     = m2au_pkg::LANES;
    localparam int STEPS = m2au_pkg::DIV_STEPS;
    localparam int MW    = m2au_pkg::MODE_W;
    localparam int NSTG  = 5 + STEPS + 1;
    localparam int PW    = 2 * W;
    localparam int SW    = PW + 2;

    localparam logic signed [SW-1:0] HALF_Q = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [W-1:0]  MAX_Q  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  MIN_Q  = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [MW-1:0]         mode;
        logic [L-1:0][W-1:0]   res;
        logic                  sat;
        logic                  dz;
        logic [L-1:0]          neg;
        logic [L-1:0]          ovf;
    } side_t;

    // Saturate a 33-bit value to 32 bits.
    function automatic logic [W-1:0] sat33(input logic signed [W:0] x);
        logic [W-1:0] r;
        if (x[W] != x[W-1])
            r = x[W] ? MIN_Q : MAX_Q;
        else
            r = x[W-1:0];
        return r;
    endfunction

    // Magnitude of a 33-bit value whose magnitude fits 32 bits.
    function automatic logic [W-1:0] mag33(input logic signed [W:0] x);
        logic signed [W:0] n;
        n = x[W] ? -x : x;
        return n[W-1:0];
    endfunction

    // Pipeline control: one shared advance for all stages past the input.
    logic [NSTG-1:0] v_reg;
    logic            adv;
    logic            load0;

    assign adv       = !v_reg[NSTG-1] || rsp_ready;
    assign load0     = adv || !v_reg[0];
    assign req_ready = load0;
    assign rsp_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (load0)
                v_reg[0] <= req_valid;
            if (adv)
                v_reg[NSTG-1:1] <= v_reg[NSTG-2:0];
        end
    end

    // Stage 0: input register.
    m2au_pkg::req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (load0)
            req_reg <= req_data;
    end

    // Stage 1: operand selection, eight products, and the simple element ops.
    logic signed [W-1:0] a_s [L];
    logic signed [W-1:0] b_s [L];
    logic signed [W-1:0] x0 [L];
    logic signed [W-1:0] y0 [L];
    logic signed [W-1:0] x1 [L];
    logic signed [W-1:0] y1 [L];
    logic                neg1_next;
    logic [W-1:0]        simp_next [L];
    logic                ssat_next;

    assign a_s[0] = req_reg.a_xx;
    assign a_s[1] = req_reg.a_xy;
    assign a_s[2] = req_reg.a_yx;
    assign a_s[3] = req_reg.a_yy;
    assign b_s[0] = req_reg.b_xx;
    assign b_s[1] = req_reg.b_xy;
    assign b_s[2] = req_reg.b_yx;
    assign b_s[3] = req_reg.b_yy;

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            x0[l] = '0;
            y0[l] = '0;
            x1[l] = '0;
            y1[l] = '0;
        end
        neg1_next = 1'b0;
        unique case (req_reg.mode) inside
            m2au_pkg::MODE_MUL:
            begin
                x0[0] = a_s[0]; y0[0] = b_s[0]; x1[0] = a_s[1]; y1[0] = b_s[2];
                x0[1] = a_s[0]; y0[1] = b_s[1]; x1[1] = a_s[1]; y1[1] = b_s[3];
                x0[2] = a_s[2]; y0[2] = b_s[0]; x1[2] = a_s[3]; y1[2] = b_s[2];
                x0[3] = a_s[2]; y0[3] = b_s[1]; x1[3] = a_s[3]; y1[3] = b_s[3];
            end
            m2au_pkg::MODE_MV:
            begin
                x0[0] = a_s[0]; y0[0] = b_s[0]; x1[0] = a_s[1]; y1[0] = b_s[1];
                x0[1] = a_s[2]; y0[1] = b_s[0]; x1[1] = a_s[3]; y1[1] = b_s[1];
            end
            m2au_pkg::MODE_VM:
            begin
                x0[0] = b_s[0]; y0[0] = a_s[0]; x1[0] = b_s[1]; y1[0] = a_s[2];
                x0[1] = b_s[0]; y0[1] = a_s[1]; x1[1] = b_s[1]; y1[1] = a_s[3];
            end
            m2au_pkg::MODE_SCALE:
            begin
                for (int l = 0; l < L; l++)
                begin
                    x0[l] = a_s[l];
                    y0[l] = b_s[0];
                end
            end
            m2au_pkg::MODE_DET, m2au_pkg::MODE_INV:
            begin
                x0[0] = a_s[0]; y0[0] = a_s[3]; x1[0] = a_s[2]; y1[0] = a_s[1];
                neg1_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Negate, add, subtract and trace, saturated to 32 bits.
    always_comb
    begin
        logic signed [W:0] s;
        ssat_next = 1'b0;
        for (int l = 0; l < L; l++)
        begin
            case (req_reg.mode)
                m2au_pkg::MODE_NEG:   s = -(W+1)'(a_s[l]);
                m2au_pkg::MODE_ADD:   s = (W+1)'(a_s[l]) + (W+1)'(b_s[l]);
                m2au_pkg::MODE_SUB:   s = (W+1)'(a_s[l]) - (W+1)'(b_s[l]);
                m2au_pkg::MODE_TRACE: s = (l == 0) ? (W+1)'(a_s[0]) + (W+1)'(a_s[3]) : '0;
                default:              s = '0;
            endcase
            simp_next[l] = sat33(s);
            if (s[W] != s[W-1])
                ssat_next = 1'b1;
        end
    end

    logic signed [PW-1:0] p0_reg [L];
    logic signed [PW-1:0] p1_reg [L];
    logic                 neg1_reg;
    logic [W-1:0]         simp1_reg [L];
    logic                 ssat1_reg;
    logic [MW-1:0]        mode1_reg;
    logic signed [W-1:0]  a1_reg [L];
    logic signed [W-1:0]  b01_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < L; l++)
            begin
                p0_reg[l]    <= PW'(x0[l]) * PW'(y0[l]);
                p1_reg[l]    <= PW'(x1[l]) * PW'(y1[l]);
                simp1_reg[l] <= simp_next[l];
                a1_reg[l]    <= a_s[l];
            end
            neg1_reg  <= neg1_next;
            ssat1_reg <= ssat_next;
            mode1_reg <= req_reg.mode;
            b01_reg   <= b_s[0];
        end
    end

    // Stage 2: exact sum of the product pair plus the rounding half.
    logic signed [SW-1:0] dsum2_reg [L];
    logic [W-1:0]         simp2_reg [L];
    logic                 ssat2_reg;
    logic [MW-1:0]        mode2_reg;
    logic signed [W-1:0]  a2_reg [L];
    logic signed [W-1:0]  b02_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < L; l++)
            begin
                dsum2_reg[l] <= SW'(p0_reg[l])
                              + (neg1_reg ? -SW'(p1_reg[l]) : SW'(p1_reg[l]))
                              + HALF_Q;
                simp2_reg[l] <= simp1_reg[l];
                a2_reg[l]    <= a1_reg[l];
            end
            ssat2_reg <= ssat1_reg;
            mode2_reg <= mode1_reg;
            b02_reg   <= b01_reg;
        end
    end

    // Stage 3: drop the fraction, saturate, and pick the per-mode result.
    logic [W-1:0] dot3 [L];
    logic         dsat3;
    logic [W-1:0] res3_next [L];
    logic         sat3_next;

    always_comb
    begin
        logic signed [SW-1:0] rq;
        dsat3 = 1'b0;
        for (int l = 0; l < L; l++)
        begin
            rq = dsum2_reg[l] >>> FRAC_BITS;
            if ((&rq[SW-1:W-1]) || !(|rq[SW-1:W-1]))
            begin
                dot3[l] = rq[W-1:0];
            end
            else
            begin
                dot3[l] = rq[SW-1] ? MIN_Q : MAX_Q;
                dsat3   = 1'b1;
            end
        end
    end

    always_comb
    begin
        sat3_next = 1'b0;
        for (int l = 0; l < L; l++)
            res3_next[l] = '0;
        unique case (mode2_reg) inside
            m2au_pkg::MODE_NEG, m2au_pkg::MODE_ADD, m2au_pkg::MODE_SUB,
            m2au_pkg::MODE_TRACE:
            begin
                for (int l = 0; l < L; l++)
                    res3_next[l] = simp2_reg[l];
                sat3_next = ssat2_reg;
            end
            m2au_pkg::MODE_MUL, m2au_pkg::MODE_MV, m2au_pkg::MODE_VM,
            m2au_pkg::MODE_SCALE, m2au_pkg::MODE_DET, m2au_pkg::MODE_INV:
            begin
                for (int l = 0; l < L; l++)
                    res3_next[l] = dot3[l];
                sat3_next = dsat3;
            end
            m2au_pkg::MODE_TRANS:
            begin
                res3_next[0] = a2_reg[0];
                res3_next[1] = a2_reg[2];
                res3_next[2] = a2_reg[1];
                res3_next[3] = a2_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    logic [W-1:0]        res3_reg [L];
    logic                sat3_reg;
    logic [MW-1:0]       mode3_reg;
    logic signed [W-1:0] a3_reg [L];
    logic signed [W-1:0] b03_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < L; l++)
            begin
                res3_reg[l] <= res3_next[l];
                a3_reg[l]   <= a2_reg[l];
            end
            sat3_reg  <= sat3_next;
            mode3_reg <= mode2_reg;
            b03_reg   <= b02_reg;
        end
    end

    // Stage 4: divider setup. Magnitudes, signs, zero divisor, and an early
    // check for quotients of 2^32 or more so the divider needs 32 bits only.
    logic                is_div3;
    logic signed [W-1:0] den3;
    logic [W-1:0]        dmag3;
    logic signed [W:0]   num3 [L];
    logic [W-1:0]        nmag3 [L];
    side_t               side_next;
    logic [L-1:0][W:0]   rem4_next;
    logic [L-1:0][W-1:0] nq4_next;

    assign is_div3 = (mode3_reg == m2au_pkg::MODE_DIV) || (mode3_reg == m2au_pkg::MODE_INV);
    assign den3    = (mode3_reg == m2au_pkg::MODE_DIV) ? b03_reg : $signed(res3_reg[0]);
    assign dmag3   = mag33((W+1)'(den3));

    always_comb
    begin
        if (mode3_reg == m2au_pkg::MODE_DIV)
        begin
            for (int l = 0; l < L; l++)
                num3[l] = (W+1)'(a3_reg[l]);
        end
        else
        begin
            num3[0] = (W+1)'(a3_reg[3]);
            num3[1] = -(W+1)'(a3_reg[1]);
            num3[2] = -(W+1)'(a3_reg[2]);
            num3[3] = (W+1)'(a3_reg[0]);
        end
        side_next.mode = mode3_reg;
        side_next.sat  = sat3_reg;
        side_next.dz   = is_div3 && (den3 == '0);
        for (int l = 0; l < L; l++)
        begin
            nmag3[l]          = mag33(num3[l]);
            side_next.res[l]  = res3_reg[l];
            side_next.neg[l]  = num3[l][W] ^ den3[W-1];
            side_next.ovf[l]  = {{W{1'b0}}, nmag3[l]}
                             >= ({{W{1'b0}}, dmag3} << (W - FRAC_BITS));
            rem4_next[l]      = {{(W+1-FRAC_BITS){1'b0}}, nmag3[l][W-1:W-FRAC_BITS]};
            nq4_next[l]       = {nmag3[l][W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end
    end

    logic [W-1:0]        den4_reg;
    logic [L-1:0][W:0]   rem4_reg;
    logic [L-1:0][W-1:0] nq4_reg;
    side_t               side_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den4_reg    <= dmag3;
            rem4_reg    <= rem4_next;
            nq4_reg     <= nq4_next;
            side_reg[0] <= side_next;
            for (int s = 1; s <= STEPS; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // Stages 5 to 36: the divider, with side data traveling alongside.
    logic [L-1:0][W-1:0] q_div;

    m2au_div u_div (
        .clk    (clk),
        .en     (adv),
        .den_in (den4_reg),
        .rem_in (rem4_reg),
        .nq_in  (nq4_reg),
        .q_out  (q_div)
    );

    // Stage 37: apply quotient signs, saturate, and form the status.
    side_t          side_f;
    logic [W-1:0]   rfin [L];
    logic           fsat;
    m2au_pkg::rsp_t rsp_next;
    m2au_pkg::rsp_t rsp_reg;

    assign side_f = side_reg[STEPS];

    always_comb
    begin
        fsat = side_f.sat;
        for (int l = 0; l < L; l++)
            rfin[l] = side_f.res[l];
        if ((side_f.mode == m2au_pkg::MODE_DIV) || (side_f.mode == m2au_pkg::MODE_INV))
        begin
            for (int l = 0; l < L; l++)
            begin
                if (side_f.dz)
                begin
                    rfin[l] = '0;
                end
                else if (side_f.ovf[l])
                begin
                    rfin[l] = side_f.neg[l] ? MIN_Q : MAX_Q;
                    fsat    = 1'b1;
                end
                else if (!side_f.neg[l])
                begin
                    if (q_div[l][W-1])
                    begin
                        rfin[l] = MAX_Q;
                        fsat    = 1'b1;
                    end
                    else
                    begin
                        rfin[l] = q_div[l];
                    end
                end
                else if (q_div[l] > {1'b1, {(W-1){1'b0}}})
                begin
                    rfin[l] = MIN_Q;
                    fsat    = 1'b1;
                end
                else
                begin
                    rfin[l] = ~q_div[l] + 1'b1;
                end
            end
        end
        rsp_next.r_xx   = rfin[0];
        rsp_next.r_xy   = rfin[1];
        rsp_next.r_yx   = rfin[2];
        rsp_next.r_yy   = rfin[3];
        rsp_next.status = side_f.dz ? m2au_pkg::ST_DZ
                        : (fsat ? m2au_pkg::ST_SAT : m2au_pkg::ST_OK);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_data = rsp_reg;

    // A divide-by-zero response carries an all-zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == m2au_pkg::ST_DZ)
        |-> (rsp_data.r_xx == '0) && (rsp_data.r_xy == '0)
         && (rsp_data.r_yx == '0) && (rsp_data.r_yy == '0))
        else $error("divide-by-zero response with nonzero result");

    // Only the three defined status codes leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == m2au_pkg::ST_OK)
                   || (rsp_data.status == m2au_pkg::ST_SAT)
                   || (rsp_data.status == m2au_pkg::ST_DZ))
        else $error("undefined status code");

    // A stalled response freezes every stage behind the input register.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(v_reg[NSTG-1:1]))
        else $error("pipeline moved during a response stall");

    // An accepted request always lands in the input stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> v_reg[0])
        else $error("accepted request lost at the input stage");

endmodule

/* sv/m2au_div.sv */
// Pipelined restoring divider for four lanes that share one divisor.
// One quotient bit per stage; depends on m2au_pkg.
module m2au_div (
    input  logic                                              clk,
    input  logic                                              en,
    input  logic [m2au_pkg::DATA_W-1:0]                       den_in,
    input  logic [m2au_pkg::LANES-1:0][m2au_pkg::DATA_W:0]    rem_in,
    input  logic [m2au_pkg::LANES-1:0][m2au_pkg::DATA_W-1:0]  nq_in,
    output logic [m2au_pkg::LANES-1:0][m2au_pkg::DATA_W-1:0]  q_out
);

    localparam int W     = m2au_pkg::DATA_W;
    localparam int L     = m2au_pkg::LANES;
    localparam int STEPS = m2au_pkg::DIV_STEPS;

    // Per stage: divisor, partial remainder, and numerator bits still to
    // shift in with quotient bits filling from the bottom.
    logic [W-1:0]          den_reg [STEPS];
    logic [L-1:0][W:0]     rem_reg [STEPS];
    logic [L-1:0][W-1:0]   nq_reg  [STEPS];

    for (genvar gs = 0; gs < STEPS; gs++) begin : g_step
        logic [W-1:0]        den_prev;
        logic [L-1:0][W:0]   rem_prev;
        logic [L-1:0][W-1:0] nq_prev;
        logic [L-1:0][W:0]   rem_next;
        logic [L-1:0][W-1:0] nq_next;

        if (gs == 0) begin : g_first
            assign den_prev = den_in;
            assign rem_prev = rem_in;
            assign nq_prev  = nq_in;
        end else begin : g_rest
            assign den_prev = den_reg[gs-1];
            assign rem_prev = rem_reg[gs-1];
            assign nq_prev  = nq_reg[gs-1];
        end

        // Shift in the next numerator bit and subtract when it fits.
        always_comb
        begin
            logic [W:0] t;
            logic       ge;
            for (int l = 0; l < L; l++)
            begin
                t  = {rem_prev[l][W-1:0], nq_prev[l][W-1]};
                ge = (t >= {1'b0, den_prev});
                rem_next[l] = ge ? (t - {1'b0, den_prev}) : t;
                nq_next[l]  = {nq_prev[l][W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[gs] <= den_prev;
                rem_reg[gs] <= rem_next;
                nq_reg[gs]  <= nq_next;
            end
        end
    end

    assign q_out = nq_reg[STEPS-1];

endmodule
